// ===== hw/rtl/msear_pkg.sv =====
// shared types and constants for the motor speed estimate and ramp block
package msear_pkg;

  // sample ring depth, a power of two so the mean is a shift
  localparam int HISTORY_DEPTH = 8;
  localparam int HIST_LOG2     = $clog2(HISTORY_DEPTH);
  localparam int SLOT_W        = (HIST_LOG2 > 0) ? HIST_LOG2 : 1;

  // field widths
  localparam int COUNT_W  = 16;
  localparam int SPEED_W  = 24;
  localparam int ANGLE_W  = 32;
  localparam int TRAVEL_W = 48;
  localparam int STEP_W   = 23;
  localparam int SCALE_W  = 24;
  localparam int REM_W    = SPEED_W + 1;
  localparam int SUM_W    = SPEED_W + HIST_LOG2;

  // stream payload widths
  localparam int IN_DATA_W  = COUNT_W + SPEED_W;
  localparam int IN_USER_W  = 2;
  localparam int OUT_DATA_W = SPEED_W + SPEED_W + ANGLE_W + TRAVEL_W;
  localparam int OUT_USER_W = 1;

  // register port
  localparam int APB_DATA_W = 32;
  localparam int APB_ADDR_W = 5;
  localparam int REG_IDX_W  = 3;

  // register reset values
  localparam logic [STEP_W-1:0]  RAMP_STEP_RST    = STEP_W'(256);
  localparam logic [STEP_W-1:0]  SPEED_LIMIT_RST  = {STEP_W{1'b1}};
  localparam logic [SCALE_W-1:0] SPEED_SCALE_RST  = SCALE_W'(65536);
  localparam logic [SCALE_W-1:0] TRAVEL_SCALE_RST = SCALE_W'(65536);

  // command kinds
  typedef enum logic [IN_USER_W-1:0] {
    CMD_TICK  = 2'd0,
    CMD_SET   = 2'd1,
    CMD_BRAKE = 2'd2,
    CMD_CLEAR = 2'd3
  } cmd_t;

  // register indexes
  typedef enum logic [REG_IDX_W-1:0] {
    REG_RAMP_MODE    = 3'd0,
    REG_RAMP_STEP    = 3'd1,
    REG_SPEED_LIMIT  = 3'd2,
    REG_SPEED_SCALE  = 3'd3,
    REG_TRAVEL_SCALE = 3'd4
  } reg_idx_t;

  // ramp mode codes
  localparam logic MODE_NORMAL = 1'b0;
  localparam logic MODE_LINEAR = 1'b1;

endpackage

// ===== hw/rtl/motor_speed_estimate_and_ramp.sv =====
// motor speed estimate and setpoint ramp, three-stage pipeline with register port
// Takes one command per cycle on the slave stream while the master stream does not
// stall (tuser = kind: tick, set target, brake, clear travel) and gives one result
// per command on the master stream. The first stage registers the command, the
// second runs the two count multipliers (speed and angle), the third updates the
// state (sample ring, running sum, ramp, travel) and loads the result register. The
// running sum makes the mean a single add and shift, so the sustained rate is one
// item per cycle when the master stream does not stall; the ready chain lets a new
// command enter while a finished result waits. The user must write registers through
// the APB port only while the stream is idle; the block itself does not enforce it.
// The reported speed is the ring sum divided by the ring depth, truncated toward zero.
module motor_speed_estimate_and_ramp (
  input  logic                              clk,
  input  logic                              rst,
  // command stream
  input  logic                              s_tvalid,
  output logic                              s_tready,
  // tdata: encoder_count[15:0], target_speed[39:16]
  input  logic [msear_pkg::IN_DATA_W-1:0]   s_tdata,
  // tuser: command kind[1:0]
  input  logic [msear_pkg::IN_USER_W-1:0]   s_tuser,
  // result stream
  output logic                              m_tvalid,
  input  logic                              m_tready,
  // tdata: measured_speed[23:0], speed_setpoint[47:24], angle_step[79:48], travel[127:80]
  output logic [msear_pkg::OUT_DATA_W-1:0]  m_tdata,
  // tuser: accepted[0]
  output logic [msear_pkg::OUT_USER_W-1:0]  m_tuser,
  // register port
  input  logic                              psel,
  input  logic                              penable,
  input  logic                              pwrite,
  input  logic [msear_pkg::APB_ADDR_W-1:0]  paddr,
  input  logic [msear_pkg::APB_DATA_W-1:0]  pwdata,
  output logic [msear_pkg::APB_DATA_W-1:0]  prdata,
  output logic                              pready
);
  import msear_pkg::*;

  // configuration registers
  logic                ramp_mode;
  logic [STEP_W-1:0]   ramp_step;
  logic [STEP_W-1:0]   speed_limit;
  logic [SCALE_W-1:0]  speed_scale;
  logic [SCALE_W-1:0]  travel_scale;

  logic                cfg_wr;
  reg_idx_t            reg_idx;

  // pipeline stage registers
  logic                      v1, v2, out_valid;
  cmd_t                      cmd1, cmd2;
  logic signed [COUNT_W-1:0] count1;
  logic signed [SPEED_W-1:0] target1, target2;
  logic signed [SPEED_W-1:0] speed2;
  logic signed [ANGLE_W-1:0] angle2;

  logic adv1, adv2, adv3;

  // block state
  logic signed [SPEED_W-1:0]  speed_history [HISTORY_DEPTH];
  logic [SLOT_W-1:0]          history_slot;
  logic signed [SUM_W-1:0]    history_sum;
  logic signed [SPEED_W-1:0]  target_value;
  logic signed [SPEED_W-1:0]  setpoint_value;
  logic [REM_W-1:0]           ramp_remaining;
  logic                       ramp_down;
  logic [TRAVEL_W-1:0]        travel_total;
  logic signed [ANGLE_W-1:0]  last_angle;

  // next state
  logic signed [SUM_W-1:0]    history_sum_next;
  logic [SLOT_W-1:0]          history_slot_next;
  logic signed [SPEED_W-1:0]  target_value_next;
  logic signed [SPEED_W-1:0]  setpoint_value_next;
  logic [REM_W-1:0]           ramp_remaining_next;
  logic                       ramp_down_next;
  logic [TRAVEL_W-1:0]        travel_total_next;
  logic signed [ANGLE_W-1:0]  last_angle_next;
  logic                       hist_write;
  logic                       hist_clear;
  logic                       accepted_next;

  // result register
  logic                       res_accepted;
  logic signed [SPEED_W-1:0]  res_mean;
  logic signed [SPEED_W-1:0]  res_setpoint;
  logic signed [ANGLE_W-1:0]  res_angle;
  logic [TRAVEL_W-1:0]        res_travel;

  // register port: always ready, write on access phase
  assign pready  = 1'b1;
  assign cfg_wr  = psel & penable & pwrite & pready;
  assign reg_idx = reg_idx_t'(paddr[APB_ADDR_W-1:2]);

  always_ff @(posedge clk) begin
    if (rst) begin
      ramp_mode    <= MODE_NORMAL;
      ramp_step    <= RAMP_STEP_RST;
      speed_limit  <= SPEED_LIMIT_RST;
      speed_scale  <= SPEED_SCALE_RST;
      travel_scale <= TRAVEL_SCALE_RST;
    end else if (cfg_wr) begin
      unique case (reg_idx)
        REG_RAMP_MODE:    ramp_mode    <= pwdata[0];
        REG_RAMP_STEP:    ramp_step    <= pwdata[STEP_W-1:0];
        REG_SPEED_LIMIT:  speed_limit  <= pwdata[STEP_W-1:0];
        REG_SPEED_SCALE:  speed_scale  <= pwdata[SCALE_W-1:0];
        REG_TRAVEL_SCALE: travel_scale <= pwdata[SCALE_W-1:0];
        default: ;
      endcase
    end
  end

  // register read mux
  always_comb begin
    prdata = '0;
    unique case (reg_idx)
      REG_RAMP_MODE:    prdata = APB_DATA_W'(ramp_mode);
      REG_RAMP_STEP:    prdata = APB_DATA_W'(ramp_step);
      REG_SPEED_LIMIT:  prdata = APB_DATA_W'(speed_limit);
      REG_SPEED_SCALE:  prdata = APB_DATA_W'(speed_scale);
      REG_TRAVEL_SCALE: prdata = APB_DATA_W'(travel_scale);
      default:          prdata = '0;
    endcase
  end

  // ready chain: each stage moves when it is empty or its successor moves
  assign adv3     = !out_valid || m_tready;
  assign adv2     = !v2 || adv3;
  assign adv1     = !v1 || adv2;
  assign s_tready = adv1;

  // stage 1: command register
  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
    end else if (adv1) begin
      v1 <= s_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv1 && s_tvalid) begin
      cmd1    <= cmd_t'(s_tuser);
      count1  <= s_tdata[COUNT_W-1:0];
      target1 <= s_tdata[COUNT_W +: SPEED_W];
    end
  end

  // stage 2: scale the count to speed and angle
  logic signed [COUNT_W+SCALE_W:0]   prod_speed;
  logic signed [COUNT_W+SCALE_W:0]   prod_angle;
  logic signed [COUNT_W+SCALE_W-8:0] speed_floor;
  logic signed [SPEED_W-1:0]         speed_sat;

  assign prod_speed  = count1 * $signed({1'b0, speed_scale});
  assign prod_angle  = count1 * $signed({1'b0, travel_scale});
  assign speed_floor = prod_speed[COUNT_W+SCALE_W:8];

  // saturate to signed speed width
  always_comb begin
    if (&speed_floor[COUNT_W+SCALE_W-8:SPEED_W-1] ||
        ~|speed_floor[COUNT_W+SCALE_W-8:SPEED_W-1]) begin
      speed_sat = speed_floor[SPEED_W-1:0];
    end else if (speed_floor[COUNT_W+SCALE_W-8]) begin
      speed_sat = {1'b1, {(SPEED_W-1){1'b0}}};
    end else begin
      speed_sat = {1'b0, {(SPEED_W-1){1'b1}}};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v2 <= 1'b0;
    end else if (adv2) begin
      v2 <= v1;
    end
  end

  always_ff @(posedge clk) begin
    if (adv2 && v1) begin
      cmd2    <= cmd1;
      target2 <= target1;
      speed2  <= speed_sat;
      angle2  <= prod_angle[ANGLE_W+7:8];
    end
  end

  // stage 3: state update
  logic                       upd;
  logic signed [SPEED_W-1:0]  hist_old;
  logic [REM_W-1:0]           step_ext;
  logic [REM_W-1:0]           ramp_move;
  logic signed [REM_W-1:0]    setpoint_ext;
  logic [SPEED_W-1:0]         target_mag;
  logic signed [REM_W-1:0]    target_diff;
  logic signed [SUM_W-1:0]    sum_biased;

  assign upd          = adv3 && v2;
  assign hist_old     = speed_history[history_slot];
  assign step_ext     = REM_W'(ramp_step);
  assign ramp_move    = (step_ext < ramp_remaining) ? step_ext : ramp_remaining;
  assign setpoint_ext = {setpoint_value[SPEED_W-1], setpoint_value};
  assign target_mag   = target2[SPEED_W-1] ? SPEED_W'(-target2) : SPEED_W'(target2);
  assign target_diff  = {target2[SPEED_W-1], target2} - setpoint_ext;

  always_comb begin
    history_sum_next    = history_sum;
    history_slot_next   = history_slot;
    target_value_next   = target_value;
    setpoint_value_next = setpoint_value;
    ramp_remaining_next = ramp_remaining;
    ramp_down_next      = ramp_down;
    travel_total_next   = travel_total;
    last_angle_next     = last_angle;
    hist_write          = 1'b0;
    hist_clear          = 1'b0;
    accepted_next       = 1'b1;
    case (cmd2)
      CMD_TICK: begin
        last_angle_next   = angle2;
        travel_total_next = travel_total + TRAVEL_W'(angle2);
        history_sum_next  = history_sum + SUM_W'(speed2) - SUM_W'(hist_old);
        hist_write        = 1'b1;
        history_slot_next = (history_slot == SLOT_W'(HISTORY_DEPTH - 1)) ?
                            '0 : history_slot + 1'b1;
        if (ramp_mode == MODE_LINEAR) begin
          if (ramp_remaining != '0) begin
            if (ramp_down) begin
              setpoint_value_next = SPEED_W'(setpoint_ext - $signed(ramp_move));
            end else begin
              setpoint_value_next = SPEED_W'(setpoint_ext + $signed(ramp_move));
            end
            ramp_remaining_next = ramp_remaining - ramp_move;
          end
        end else begin
          setpoint_value_next = target_value;
          ramp_remaining_next = '0;
          ramp_down_next      = 1'b0;
        end
      end
      CMD_SET: begin
        if (target_mag > SPEED_W'(speed_limit)) begin
          accepted_next = 1'b0;
        end else begin
          target_value_next = target2;
          if (ramp_mode == MODE_LINEAR) begin
            ramp_down_next      = target_diff[REM_W-1];
            ramp_remaining_next = target_diff[REM_W-1] ? REM_W'(-target_diff) :
                                                         REM_W'(target_diff);
          end else begin
            setpoint_value_next = target2;
            ramp_remaining_next = '0;
            ramp_down_next      = 1'b0;
          end
        end
      end
      CMD_BRAKE: begin
        target_value_next   = '0;
        setpoint_value_next = '0;
        ramp_remaining_next = '0;
        ramp_down_next      = 1'b0;
        history_sum_next    = '0;
        hist_clear          = 1'b1;
      end
      default: begin
        travel_total_next = '0;
      end
    endcase
  end

  // mean of the ring, truncated toward zero
  assign sum_biased = history_sum_next[SUM_W-1] ?
                      history_sum_next + SUM_W'(HISTORY_DEPTH - 1) : history_sum_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      history_slot   <= '0;
      history_sum    <= '0;
      target_value   <= '0;
      setpoint_value <= '0;
      ramp_remaining <= '0;
      ramp_down      <= 1'b0;
      travel_total   <= '0;
      last_angle     <= '0;
    end else if (upd) begin
      history_slot   <= history_slot_next;
      history_sum    <= history_sum_next;
      target_value   <= target_value_next;
      setpoint_value <= setpoint_value_next;
      ramp_remaining <= ramp_remaining_next;
      ramp_down      <= ramp_down_next;
      travel_total   <= travel_total_next;
      last_angle     <= last_angle_next;
    end
  end

  // sample ring
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < HISTORY_DEPTH; i++) begin
        speed_history[i] <= '0;
      end
    end else if (upd && hist_clear) begin
      for (int i = 0; i < HISTORY_DEPTH; i++) begin
        speed_history[i] <= '0;
      end
    end else if (upd && hist_write) begin
      speed_history[history_slot] <= speed2;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (adv3) begin
      out_valid <= v2;
    end
  end

  always_ff @(posedge clk) begin
    if (upd) begin
      res_accepted <= accepted_next;
      res_mean     <= sum_biased[HIST_LOG2 +: SPEED_W];
      res_setpoint <= setpoint_value_next;
      res_angle    <= last_angle_next;
      res_travel   <= travel_total_next;
    end
  end

  assign m_tvalid = out_valid;
  assign m_tuser  = res_accepted;
  assign m_tdata  = {res_travel, res_angle, res_setpoint, res_mean};

endmodule

// ===== tb/tb_motor_speed_estimate_and_ramp.sv =====
// testbench for the motor speed estimate and setpoint ramp block, self-checking
`timescale 1ns / 1ps

module tb_motor_speed_estimate_and_ramp;
  import msear_pkg::*;

  localparam int RESET_CYCLES = 8;
  localparam int DRAIN_CYCLES = 8;
  localparam int HOLD_CYCLES = 300;
  localparam int HOLD_AFTER = 400;
  localparam int CYCLE_LIMIT = 200000;
  localparam int RANDOM_PHASES = 5;
  localparam int PHASE_ITEMS = 245;
  localparam longint SPEED_HI = 64'sd8388607;
  localparam longint SPEED_LO = -64'sd8388608;
  localparam logic [31:0] STEP_MAX = 32'h007F_FFFF;
  localparam logic [31:0] SCALE_MAX = 32'h00FF_FFFF;
  localparam logic [REG_IDX_W-1:0] UNMAPPED_REG_IDX = 3'd5;

  typedef struct {
    logic                accepted;
    logic [SPEED_W-1:0]  speed;
    logic [SPEED_W-1:0]  setpoint;
    logic [ANGLE_W-1:0]  angle;
    logic [TRAVEL_W-1:0] travel;
  } motor_result_t;

  // predicts speed mean, setpoint ramp and travel, and checks each result transfer
  class speed_ramp_tracker;
    logic               ramp_mode;
    logic [STEP_W-1:0]  ramp_step;
    logic [STEP_W-1:0]  speed_limit;
    logic [SCALE_W-1:0] speed_scale;
    logic [SCALE_W-1:0] travel_scale;

    longint              samples[HISTORY_DEPTH];
    int                  slot;
    longint              sample_sum;
    longint              target;
    longint              setpoint;
    longint              ramp_left;
    bit                  ramp_down;
    logic [TRAVEL_W-1:0] travel_total;
    logic [ANGLE_W-1:0]  last_angle;

    motor_result_t pending_results[$];
    int mismatches, results_checked;
    int n_ticks, n_sets, n_refused, n_brakes, n_clears;

    function new();
      ramp_mode = MODE_NORMAL;
      ramp_step = RAMP_STEP_RST;
      speed_limit = SPEED_LIMIT_RST;
      speed_scale = SPEED_SCALE_RST;
      travel_scale = TRAVEL_SCALE_RST;
      foreach (samples[i]) samples[i] = 0;
      slot = 0;
      sample_sum = 0;
      target = 0;
      setpoint = 0;
      ramp_left = 0;
      ramp_down = 0;
      travel_total = '0;
      last_angle = '0;
    endfunction

    // register write, masked to width, unknown index ignored
    function void write_register(logic [REG_IDX_W-1:0] idx, logic [31:0] value);
      case (idx)
        REG_RAMP_MODE:    ramp_mode = value[0];
        REG_RAMP_STEP:    ramp_step = value[STEP_W-1:0];
        REG_SPEED_LIMIT:  speed_limit = value[STEP_W-1:0];
        REG_SPEED_SCALE:  speed_scale = value[SCALE_W-1:0];
        REG_TRAVEL_SCALE: travel_scale = value[SCALE_W-1:0];
        default: ;
      endcase
    endfunction

    // one accepted command transfer, one expected result
    function void note_command(cmd_t cmd, logic signed [COUNT_W-1:0] count,
                               logic signed [SPEED_W-1:0] tgt);
      motor_result_t r;
      logic ok;
      longint spd, ang, mv, mag, distance;
      ok = 1'b1;
      case (cmd)
        CMD_TICK: begin
          n_ticks++;
          spd = (longint'(count) * longint'(speed_scale)) >>> 8;
          ang = (longint'(count) * longint'(travel_scale)) >>> 8;
          if (spd > SPEED_HI) spd = SPEED_HI;
          if (spd < SPEED_LO) spd = SPEED_LO;
          last_angle = ang[ANGLE_W-1:0];
          travel_total = travel_total + ang[TRAVEL_W-1:0];
          sample_sum += spd - samples[slot];
          samples[slot] = spd;
          slot = (slot + 1) % HISTORY_DEPTH;
          if (ramp_mode == MODE_LINEAR) begin
            // ramp step, the last one stops exactly at the target
            if (ramp_left > 0) begin
              mv = (longint'(ramp_step) < ramp_left) ? longint'(ramp_step) : ramp_left;
              setpoint = ramp_down ? setpoint - mv : setpoint + mv;
              ramp_left -= mv;
            end
          end else begin
            setpoint = target;
            ramp_left = 0;
            ramp_down = 0;
          end
        end
        CMD_SET: begin
          n_sets++;
          mag = (tgt < 0) ? -longint'(tgt) : longint'(tgt);
          if (mag > longint'(speed_limit)) begin
            ok = 1'b0;
            n_refused++;
          end else begin
            target = longint'(tgt);
            if (ramp_mode == MODE_LINEAR) begin
              distance = target - setpoint;
              ramp_down = (distance < 0);
              ramp_left = (distance < 0) ? -distance : distance;
            end else begin
              setpoint = target;
              ramp_left = 0;
              ramp_down = 0;
            end
          end
        end
        CMD_BRAKE: begin
          // ring slot survives a brake
          n_brakes++;
          target = 0;
          setpoint = 0;
          ramp_left = 0;
          ramp_down = 0;
          foreach (samples[i]) samples[i] = 0;
          sample_sum = 0;
        end
        default: begin
          n_clears++;
          travel_total = '0;
        end
      endcase
      spd = sample_sum / HISTORY_DEPTH;
      r.accepted = ok;
      r.speed = spd[SPEED_W-1:0];
      r.setpoint = setpoint[SPEED_W-1:0];
      r.angle = last_angle;
      r.travel = travel_total;
      pending_results.push_back(r);
    endfunction

    function void compare_field(string field, logic [TRAVEL_W-1:0] want,
                                logic [TRAVEL_W-1:0] got);
      if (want !== got) begin
        mismatches++;
        $display("%0t: %s mismatch, expected %h actual %h", $time, field, want, got);
      end
    endfunction

    // one result transfer against the oldest expectation
    function void check_result(logic [OUT_USER_W-1:0] user, logic [OUT_DATA_W-1:0] data);
      motor_result_t r;
      if (pending_results.size() == 0) begin
        mismatches++;
        $display("%0t: unexpected result, expected none actual %h/%h", $time, user, data);
        return;
      end
      r = pending_results.pop_front();
      results_checked++;
      compare_field("accepted", TRAVEL_W'(r.accepted), TRAVEL_W'(user[0]));
      compare_field("measured_speed", TRAVEL_W'(r.speed), TRAVEL_W'(data[23:0]));
      compare_field("speed_setpoint", TRAVEL_W'(r.setpoint), TRAVEL_W'(data[47:24]));
      compare_field("angle_step", TRAVEL_W'(r.angle), TRAVEL_W'(data[79:48]));
      compare_field("travel", r.travel, data[127:80]);
    endfunction
  endclass

  logic clk;
  logic rst = 1'b1;
  logic s_tvalid = 1'b0;
  logic s_tready;
  // tdata: encoder_count[15:0], target_speed[39:16]
  logic [IN_DATA_W-1:0] s_tdata = '0;
  // tuser: command kind[1:0]
  logic [IN_USER_W-1:0] s_tuser = '0;
  logic m_tvalid;
  logic m_tready = 1'b0;
  // tdata: measured_speed[23:0], speed_setpoint[47:24], angle_step[79:48], travel[127:80]
  logic [OUT_DATA_W-1:0] m_tdata;
  // tuser: accepted[0]
  logic [OUT_USER_W-1:0] m_tuser;
  logic psel = 1'b0;
  logic penable = 1'b0;
  logic pwrite = 1'b0;
  logic [APB_ADDR_W-1:0] paddr = '0;
  logic [APB_DATA_W-1:0] pwdata = '0;
  logic [APB_DATA_W-1:0] prdata;
  logic pready;

  speed_ramp_tracker model = new;
  int cycle_count = 0;
  int burst_left = 0;
  int hold_left = 0;
  bit hold_done = 0;
  int settings_used = 0;

  motor_speed_estimate_and_ramp DUT (
    .clk(clk), .rst(rst),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // run limit
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("Some tests failed");
      $finish;
    end
  end

  // result side: check transfers, stall on a cycle pattern, one long hold-off
  always @(posedge clk) begin
    if (!rst && m_tvalid && m_tready)
      model.check_result(m_tuser, m_tdata);
    if (hold_left > 0) begin
      hold_left <= hold_left - 1;
      m_tready <= 1'b0;
    end else if (!hold_done && !rst && model.results_checked >= HOLD_AFTER && s_tvalid) begin
      hold_done <= 1'b1;
      hold_left <= HOLD_CYCLES;
      m_tready <= 1'b0;
    end else begin
      case (cycle_count[7:6])
        2'd0: m_tready <= 1'b1;
        2'd1: m_tready <= ($urandom_range(0, 3) != 0);
        2'd2: m_tready <= ($urandom_range(0, 3) == 0);
        default: m_tready <= cycle_count[0];
      endcase
    end
  end

  // register write: setup cycle, then access cycle
  task automatic apb_write(logic [REG_IDX_W-1:0] idx, logic [31:0] value);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= APB_ADDR_W'({idx, 2'b00});
    pwdata <= value;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    model.write_register(idx, value);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    @(posedge clk);
  endtask

  task automatic configure(logic [31:0] mode, logic [31:0] step, logic [31:0] limit,
                           logic [31:0] sscale, logic [31:0] tscale);
    apb_write(REG_RAMP_MODE, mode);
    apb_write(REG_RAMP_STEP, step);
    apb_write(REG_SPEED_LIMIT, limit);
    apb_write(REG_SPEED_SCALE, sscale);
    apb_write(REG_TRAVEL_SCALE, tscale);
    settings_used++;
  endtask

  // command transfer, sent in bursts with random gaps
  task automatic send_command(cmd_t cmd, logic signed [COUNT_W-1:0] count,
                              logic signed [SPEED_W-1:0] tgt);
    int gap;
    if (burst_left == 0) begin
      burst_left = ($urandom_range(0, 7) == 0) ? 64 : $urandom_range(1, 16);
      gap = $urandom_range(0, 5);
      if (gap > 0) begin
        s_tvalid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    burst_left--;
    s_tvalid <= 1'b1;
    s_tuser <= cmd;
    s_tdata <= {tgt, count};
    do @(posedge clk); while (!s_tready);
    model.note_command(cmd, count, tgt);
  endtask

  // stop sending and let every expected result come out
  task automatic settle();
    s_tvalid <= 1'b0;
    burst_left = 0;
    while (model.pending_results.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic random_phase(int n_items);
    int pick;
    logic signed [COUNT_W-1:0] count;
    logic signed [SPEED_W-1:0] tgt;
    longint mag;
    for (int i = 0; i < n_items; i++) begin
      pick = $urandom_range(0, 99);
      count = ($urandom_range(0, 6) == 0) ? COUNT_W'($urandom_range(0, 16) - 8)
                                          : COUNT_W'($urandom);
      mag = longint'($urandom_range(0, int'(model.speed_limit)));
      tgt = ($urandom_range(0, 1) == 1) ? SPEED_W'(-mag) : SPEED_W'(mag);
      if (pick < 68) begin
        send_command(CMD_TICK, count, tgt);
      end else if (pick < 84) begin
        // mostly valid targets, some zero-distance, some out of range
        case ($urandom_range(0, 7))
          0, 1: tgt = SPEED_W'($urandom);
          2: tgt = model.setpoint[SPEED_W-1:0];
          default: ;
        endcase
        send_command(CMD_SET, count, tgt);
      end else if (pick < 90) begin
        send_command(CMD_BRAKE, count, tgt);
      end else begin
        send_command(CMD_CLEAR, count, tgt);
      end
    end
  endtask

  initial begin
    repeat (RESET_CYCLES) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // normal mode, reset-like scales, field extremes
    configure(MODE_NORMAL, 32'd256, SCALE_MAX, 32'd65536, 32'd65536);
    send_command(CMD_TICK, 16'sh7FFF, '0);
    send_command(CMD_TICK, 16'sh8000, '0);
    send_command(CMD_TICK, 16'sh0000, 24'shFFFFFF);
    send_command(CMD_SET, 16'shFFFF, 24'sh7FFFFF);
    send_command(CMD_SET, '0, 24'sh800000);
    send_command(CMD_TICK, 16'sh0001, '0);
    send_command(CMD_CLEAR, '0, '0);
    send_command(CMD_BRAKE, '0, '0);
    send_command(CMD_TICK, 16'shFFFF, '0);
    settle();

    // linear ramp with clamp at the target, saturated speeds, refusals
    configure(32'hFFFF_FFFF, 32'd7, 32'd50000, SCALE_MAX, SCALE_MAX);
    apb_write(UNMAPPED_REG_IDX, 32'hFFFF_FFFF);
    send_command(CMD_TICK, 16'sh7FFF, '0);
    send_command(CMD_TICK, 16'sh8000, '0);
    send_command(CMD_SET, '0, 24'sd20);
    send_command(CMD_TICK, 16'sd3, '0);
    send_command(CMD_TICK, 16'sd3, '0);
    send_command(CMD_TICK, 16'sd3, '0);
    send_command(CMD_SET, '0, 24'sd50001);
    send_command(CMD_SET, '0, -24'sd50000);
    send_command(CMD_TICK, 16'sd5, '0);
    send_command(CMD_BRAKE, '0, '0);
    send_command(CMD_SET, '0, '0);
    send_command(CMD_TICK, 16'sd1, '0);
    settle();

    // zero ramp step and zero scales
    configure(MODE_LINEAR, 32'd0, 32'd1000, 32'd0, 32'd0);
    send_command(CMD_SET, '0, 24'sd1001);
    send_command(CMD_SET, '0, 24'sd500);
    send_command(CMD_TICK, 16'sd100, '0);
    send_command(CMD_TICK, -16'sd100, '0);
    settle();

    // random phases, one register setting each
    for (int p = 0; p < RANDOM_PHASES; p++) begin
      case (p)
        0: configure(MODE_LINEAR, $urandom_range(1, 4096), $urandom_range(1, STEP_MAX),
                     $urandom_range(0, SCALE_MAX), $urandom_range(0, SCALE_MAX));
        1: configure(MODE_NORMAL, 32'd256, SCALE_MAX, SCALE_MAX, SCALE_MAX);
        2: configure(MODE_LINEAR, 32'd1, 32'd300, 32'd65536, 32'd65536);
        3: configure(MODE_LINEAR, STEP_MAX, STEP_MAX, $urandom_range(0, SCALE_MAX), 32'd0);
        default: configure(MODE_LINEAR, $urandom_range(1, 200000), $urandom_range(0, STEP_MAX),
                           $urandom, $urandom);
      endcase
      random_phase(PHASE_ITEMS);
      settle();
    end

    $display("run covered %0d ticks, %0d target requests (%0d refused), %0d brakes, %0d clears",
             model.n_ticks, model.n_sets, model.n_refused, model.n_brakes, model.n_clears);
    $display("over %0d register settings, %0d results checked, long result hold-off %0s",
             settings_used, model.results_checked, hold_done ? "done" : "not reached");
    if (model.mismatches == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
hw/rtl/msear_pkg.sv
hw/rtl/motor_speed_estimate_and_ramp.sv
tb/tb_motor_speed_estimate_and_ramp.sv
